@@ rtl/depq_pkg.sv @@
// Shared constants, command codes and heap request types for the
// double-ended priority queue. No dependencies.
package depq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_INSERT  = 2'd1;
  localparam logic [1:0] CMD_DEL_MIN = 2'd2;
  localparam logic [1:0] CMD_DEL_MAX = 2'd3;

  typedef enum logic [1:0] {
    HOP_CLEAR,
    HOP_PUSH,
    HOP_POP
  } heap_op_t;

  typedef struct packed {
    logic     valid;
    heap_op_t op;
  } heap_req_t;

  function automatic logic goes_first(input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b,
                                      input logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

@@ rtl/depq_ifs.sv @@
// Valid/ready channel interfaces for command beats and result beats.
// Depends on depq_pkg.
interface depq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [depq_pkg::VAL_W-1:0]   value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface depq_out_if #(parameter int unsigned CNT_W = depq_pkg::CNT_W_DEF);
  logic                                valid;
  logic                                ready;
  logic                                empty_res;
  logic signed [depq_pkg::VAL_W-1:0]   largest;
  logic signed [depq_pkg::VAL_W-1:0]   smallest;
  logic [CNT_W-1:0]                    live_total;
  logic                                ignored;
  modport source (output valid, empty_res, largest, smallest, live_total, ignored,
                  input ready);
  modport sink   (input valid, empty_res, largest, smallest, live_total, ignored,
                  output ready);
endinterface

@@ rtl/depq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module depq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/depq_heap.sv @@
// One binary heap (min or max) of value/tag entries held in a depq_ram,
// with push and pop sequenced one level at a time; clear only resets the size. Depends on depq_pkg.
module depq_heap #(
  parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF,
  parameter bit          IS_MAX   = 1'b0,
  localparam int unsigned IDX_W   = $clog2(CAPACITY),
  localparam int unsigned SZ_W    = $clog2(CAPACITY + 1),
  localparam int unsigned E_W     = depq_pkg::VAL_W + IDX_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  depq_pkg::heap_req_t req,
  input  logic [E_W-1:0]      req_ent,
  output logic                busy,
  output logic [SZ_W-1:0]     size,
  output logic [E_W-1:0]      top
);
  localparam int unsigned VW = depq_pkg::VAL_W;

  typedef enum logic [2:0] {
    H_IDLE, H_UP, H_UP_CMP, H_DN_LAST, H_DN, H_DN_L, H_DN_R, H_DN_CMP
  } hstate_t;

  hstate_t          st_r, st_nxt;
  logic [SZ_W-1:0]  size_r, size_nxt;
  logic [SZ_W-1:0]  i_r, i_nxt;
  logic [SZ_W-1:0]  bidx_r, bidx_nxt;
  logic [E_W-1:0]   cur_r, cur_nxt;
  logic [E_W-1:0]   best_r, best_nxt;
  logic             bch_r, bch_nxt;
  logic [E_W-1:0]   top_r, top_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [E_W-1:0]   wdata, rdata;
  logic [SZ_W-1:0]  par, szm1;
  logic [SZ_W:0]    lft, rgt;

  assign par  = (i_r - SZ_W'(1)) >> 1;
  assign szm1 = size_r - SZ_W'(1);
  assign lft  = {i_r, 1'b1};
  assign rgt  = lft + (SZ_W + 1)'(1);

  depq_ram #(.WIDTH(E_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    st_nxt   = st_r;
    size_nxt = size_r;
    i_nxt    = i_r;
    bidx_nxt = bidx_r;
    cur_nxt  = cur_r;
    best_nxt = best_r;
    bch_nxt  = bch_r;
    top_nxt  = top_r;
    we       = 1'b0;
    waddr    = i_r[IDX_W-1:0];
    wdata    = cur_r;
    re       = 1'b0;
    raddr    = '0;
    unique case (st_r)
      H_IDLE: begin
        if (req.valid) begin
          unique case (req.op)
            depq_pkg::HOP_CLEAR: size_nxt = '0;
            depq_pkg::HOP_PUSH: begin
              if (size_r < SZ_W'(CAPACITY)) begin
                i_nxt    = size_r;
                cur_nxt  = req_ent;
                size_nxt = size_r + SZ_W'(1);
                st_nxt   = H_UP;
              end
            end
            depq_pkg::HOP_POP: begin
              if (size_r != '0) begin
                size_nxt = szm1;
                re       = 1'b1;
                raddr    = szm1[IDX_W-1:0];
                st_nxt   = H_DN_LAST;
              end
            end
            default: ;
          endcase
        end
      end
      H_UP: begin
        if (i_r == '0) begin
          we      = 1'b1;
          top_nxt = cur_r;
          st_nxt  = H_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = par[IDX_W-1:0];
          st_nxt = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (depq_pkg::goes_first(cur_r[E_W-1 -: VW], rdata[E_W-1 -: VW], IS_MAX)) begin
          wdata  = rdata;
          i_nxt  = par;
          st_nxt = H_UP;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      H_DN_LAST: begin
        cur_nxt = rdata;
        i_nxt   = '0;
        st_nxt  = (size_r == '0) ? H_IDLE : H_DN;
      end
      H_DN: begin
        if (lft >= {1'b0, size_r}) begin
          we = 1'b1;
          if (i_r == '0) top_nxt = cur_r;
          st_nxt = H_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = lft[IDX_W-1:0];
          st_nxt = H_DN_L;
        end
      end
      H_DN_L: begin
        if (depq_pkg::goes_first(rdata[E_W-1 -: VW], cur_r[E_W-1 -: VW], IS_MAX)) begin
          best_nxt = rdata;
          bch_nxt  = 1'b1;
          bidx_nxt = lft[SZ_W-1:0];
        end else begin
          best_nxt = cur_r;
          bch_nxt  = 1'b0;
        end
        if (rgt < {1'b0, size_r}) begin
          re     = 1'b1;
          raddr  = rgt[IDX_W-1:0];
          st_nxt = H_DN_R;
        end else begin
          st_nxt = H_DN_CMP;
        end
      end
      H_DN_R: begin
        if (depq_pkg::goes_first(rdata[E_W-1 -: VW], best_r[E_W-1 -: VW], IS_MAX)) begin
          best_nxt = rdata;
          bch_nxt  = 1'b1;
          bidx_nxt = rgt[SZ_W-1:0];
        end
        st_nxt = H_DN_CMP;
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (bch_r) begin
          wdata = best_r;
          if (i_r == '0) top_nxt = best_r;
          i_nxt  = bidx_r;
          st_nxt = H_DN;
        end else begin
          if (i_r == '0) top_nxt = cur_r;
          st_nxt = H_IDLE;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      size_r <= '0;
    end else begin
      st_r   <= st_nxt;
      size_r <= size_nxt;
    end
    i_r    <= i_nxt;
    bidx_r <= bidx_nxt;
    cur_r  <= cur_nxt;
    best_r <= best_nxt;
    bch_r  <= bch_nxt;
    top_r  <= top_nxt;
  end

  assign busy = (st_r != H_IDLE);
  assign size = size_r;
  assign top  = top_r;
endmodule

@@ rtl/double_ended_priority_queue.sv @@
// Top level: command sequencer, live-mark memory and the min and max heaps.
// Depends on depq_pkg, depq_ifs, depq_ram and depq_heap.
//
//  channel  | dir | beat contents
//  in_ch    | in  | cmd, value
//  out_ch   | out | empty_res, largest, smallest, live_total, ignored
//
// One command at a time. Insert pushes into both heaps, each climbing one level at a time,
// then checks the tops. Delete first drops each stale top, by a mark check and a full pop,
// from both heaps, then pops the requested heap, which sifts down one level at a time, and
// checks the tops again if entries remain; the single read port of each heap RAM serializes this.
// Reset is synchronous; live marks are gated by the tag counter, so no clearing pass.
// A result waiting on out_ch stalls only the next result, not the next command beat.
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  depq_in_if.sink         in_ch,
  depq_out_if.source      out_ch
);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned SZ_W  = $clog2(CAPACITY + 1);
  localparam int unsigned VW    = depq_pkg::VAL_W;
  localparam int unsigned E_W   = VW + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH_W, S_PG_CHK, S_PG_RD, S_PG_W, S_DEL_W, S_OUT
  } state_t;

  state_t          st_r, st_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic            ign_r, ign_nxt;
  logic [SZ_W-1:0] live_r, live_nxt;
  logic [SZ_W-1:0] tag_r, tag_nxt;
  logic            hsel_r, hsel_nxt;
  logic            post_r, post_nxt;

  logic            ov_r;
  logic            oempty_r, oign_r;
  logic [VW-1:0]   obig_r, osmall_r;
  logic [SZ_W-1:0] olive_r;

  depq_pkg::heap_req_t lreq, hreq;
  logic [E_W-1:0]      push_ent, ltop, htop, stop, dtop;
  logic [SZ_W-1:0]     lsize, hsize, ssize;
  logic                lbusy, hbusy, sbusy, adv, del_high;

  logic                mwe, mwdata, mre, mrdata;
  logic [IDX_W-1:0]    mwaddr, mraddr;

  depq_heap #(.CAPACITY(CAPACITY), .IS_MAX(1'b0)) u_low (
    .clk(clk), .rst_n(rst_n), .req(lreq), .req_ent(push_ent),
    .busy(lbusy), .size(lsize), .top(ltop)
  );

  depq_heap #(.CAPACITY(CAPACITY), .IS_MAX(1'b1)) u_high (
    .clk(clk), .rst_n(rst_n), .req(hreq), .req_ent(push_ent),
    .busy(hbusy), .size(hsize), .top(htop)
  );

  depq_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_marks (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .re(mre), .raddr(mraddr), .rdata(mrdata)
  );

  assign push_ent = {in_ch.value, tag_r[IDX_W-1:0]};
  assign stop     = hsel_r ? htop : ltop;
  assign ssize    = hsel_r ? hsize : lsize;
  assign sbusy    = hsel_r ? hbusy : lbusy;
  assign del_high = (cmd_r == depq_pkg::CMD_DEL_MAX);
  assign dtop     = del_high ? htop : ltop;
  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    ign_nxt  = ign_r;
    live_nxt = live_r;
    tag_nxt  = tag_r;
    hsel_nxt = hsel_r;
    post_nxt = post_r;
    lreq     = '{valid: 1'b0, op: depq_pkg::HOP_CLEAR};
    hreq     = '{valid: 1'b0, op: depq_pkg::HOP_CLEAR};
    mwe      = 1'b0;
    mwaddr   = tag_r[IDX_W-1:0];
    mwdata   = 1'b1;
    mre      = 1'b0;
    mraddr   = stop[IDX_W-1:0];
    adv      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          ign_nxt = 1'b0;
          unique case (in_ch.cmd)
            depq_pkg::CMD_CLEAR: begin
              lreq     = '{valid: 1'b1, op: depq_pkg::HOP_CLEAR};
              hreq     = '{valid: 1'b1, op: depq_pkg::HOP_CLEAR};
              live_nxt = '0;
              tag_nxt  = '0;
              st_nxt   = S_OUT;
            end
            depq_pkg::CMD_INSERT: begin
              if (tag_r >= SZ_W'(CAPACITY)) begin
                ign_nxt = 1'b1;
                st_nxt  = S_OUT;
              end else begin
                mwe      = 1'b1;
                lreq     = '{valid: 1'b1, op: depq_pkg::HOP_PUSH};
                hreq     = '{valid: 1'b1, op: depq_pkg::HOP_PUSH};
                tag_nxt  = tag_r + SZ_W'(1);
                live_nxt = live_r + SZ_W'(1);
                st_nxt   = S_PUSH_W;
              end
            end
            default: begin
              if (live_r == '0) begin
                lreq    = '{valid: 1'b1, op: depq_pkg::HOP_CLEAR};
                hreq    = '{valid: 1'b1, op: depq_pkg::HOP_CLEAR};
                ign_nxt = 1'b1;
                st_nxt  = S_OUT;
              end else begin
                hsel_nxt = 1'b0;
                post_nxt = 1'b0;
                st_nxt   = S_PG_CHK;
              end
            end
          endcase
        end
      end
      S_PUSH_W: begin
        if (!lbusy && !hbusy) begin
          hsel_nxt = 1'b0;
          post_nxt = 1'b1;
          st_nxt   = S_PG_CHK;
        end
      end
      S_PG_CHK: begin
        if (ssize == '0) begin
          adv = 1'b1;
        end else begin
          mre    = 1'b1;
          st_nxt = S_PG_RD;
        end
      end
      S_PG_RD: begin
        if (mrdata) begin
          adv = 1'b1;
        end else begin
          if (hsel_r) hreq = '{valid: 1'b1, op: depq_pkg::HOP_POP};
          else        lreq = '{valid: 1'b1, op: depq_pkg::HOP_POP};
          st_nxt = S_PG_W;
        end
      end
      S_PG_W: begin
        if (!sbusy) st_nxt = S_PG_CHK;
      end
      S_DEL_W: begin
        if (!lbusy && !hbusy) begin
          hsel_nxt = 1'b0;
          post_nxt = 1'b1;
          st_nxt   = (live_r != '0) ? S_PG_CHK : S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    // top purged: move on to the high heap, or, with both heaps purged, finish or take the requested delete
    if (adv) begin
      if (!hsel_r) begin
        hsel_nxt = 1'b1;
        st_nxt   = S_PG_CHK;
      end else if (post_r) begin
        st_nxt = S_OUT;
      end else begin
        if (del_high) hreq = '{valid: 1'b1, op: depq_pkg::HOP_POP};
        else          lreq = '{valid: 1'b1, op: depq_pkg::HOP_POP};
        mwe      = 1'b1;
        mwaddr   = dtop[IDX_W-1:0];
        mwdata   = 1'b0;
        live_nxt = live_r - SZ_W'(1);
        st_nxt   = S_DEL_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      live_r <= '0;
      tag_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      live_r <= live_nxt;
      tag_r  <= tag_nxt;
      if (st_r == S_OUT && (!ov_r || out_ch.ready)) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
    cmd_r  <= cmd_nxt;
    ign_r  <= ign_nxt;
    hsel_r <= hsel_nxt;
    post_r <= post_nxt;
    if (st_r == S_OUT && (!ov_r || out_ch.ready)) begin
      oempty_r <= (live_r == '0);
      oign_r   <= ign_r;
      olive_r  <= live_r;
      obig_r   <= (live_r != '0 && hsize != '0) ? htop[E_W-1 -: VW] : '0;
      osmall_r <= (live_r != '0 && lsize != '0) ? ltop[E_W-1 -: VW] : '0;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.empty_res  = oempty_r;
  assign out_ch.largest    = obig_r;
  assign out_ch.smallest   = osmall_r;
  assign out_ch.live_total = olive_r;
  assign out_ch.ignored    = oign_r;
endmodule

@@ rtl/depq_checker.sv @@
// Port-level checks for double_ended_priority_queue, bound to the top level.
// Depends on depq_pkg.
module depq_checker #(
  parameter int unsigned CNT_W = depq_pkg::CNT_W_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              empty_res,
  input logic signed [depq_pkg::VAL_W-1:0] largest,
  input logic signed [depq_pkg::VAL_W-1:0] smallest,
  input logic [CNT_W-1:0]                  live_total
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(largest) && $stable(smallest))
    else $error("result beat changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_res |-> largest == 0 && smallest == 0 && live_total == 0)
    else $error("empty result carries values");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty_res |-> largest >= smallest && live_total != 0)
    else $error("largest below smallest");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command beat taken while busy");
endmodule

bind double_ended_priority_queue depq_checker #(.CNT_W($clog2(CAPACITY + 1))) u_depq_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .empty_res(out_ch.empty_res), .largest(out_ch.largest),
  .smallest(out_ch.smallest), .live_total(out_ch.live_total)
);

@@ test/tb_top.sv @@
// Testbench for double_ended_priority_queue: random and directed command beats
// checked against a live-value multiset predictor. Depends on depq_pkg, depq_ifs.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned TAG_LIMIT = depq_pkg::CAPACITY_DEF;

  typedef struct {
    bit          empty_res;
    int          largest;
    int          smallest;
    bit [10:0]   live_total;
    bit          ignored;
  } queue_status_t;

  class depq_scoreboard;
    int            live_vals[$];
    int unsigned   tags_used;
    queue_status_t pending[$];
    int            errors;

    function new();
      tags_used = 0;
      errors = 0;
    endfunction

    function void note_command(logic [1:0] cmd, int value);
      queue_status_t st;
      int pick;
      st.ignored = 0;
      case (cmd)
        depq_pkg::CMD_CLEAR: begin
          live_vals.delete();
          tags_used = 0;
        end
        depq_pkg::CMD_INSERT: begin
          if (tags_used >= TAG_LIMIT) begin
            st.ignored = 1;
          end else begin
            live_vals.push_back(value);
            tags_used++;
          end
        end
        default: begin
          if (live_vals.size() == 0) begin
            st.ignored = 1;
          end else begin
            pick = 0;
            foreach (live_vals[i]) begin
              if (cmd == depq_pkg::CMD_DEL_MIN ? live_vals[i] < live_vals[pick]
                                               : live_vals[i] > live_vals[pick])
                pick = i;
            end
            live_vals.delete(pick);
          end
        end
      endcase
      st.empty_res = (live_vals.size() == 0);
      st.live_total = 11'(live_vals.size());
      st.largest = 0;
      st.smallest = 0;
      foreach (live_vals[i]) begin
        if (i == 0 || live_vals[i] > st.largest) st.largest = live_vals[i];
        if (i == 0 || live_vals[i] < st.smallest) st.smallest = live_vals[i];
      end
      pending.push_back(st);
    endfunction

    function void check_status(queue_status_t got);
      queue_status_t exp;
      if (pending.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0d actual %0d", exp.empty_res, got.empty_res);
        errors++;
      end
      if (got.largest !== exp.largest) begin
        $error("largest: expected %0d actual %0d", exp.largest, got.largest);
        errors++;
      end
      if (got.smallest !== exp.smallest) begin
        $error("smallest: expected %0d actual %0d", exp.smallest, got.smallest);
        errors++;
      end
      if (got.live_total !== exp.live_total) begin
        $error("live_total: expected %0d actual %0d", exp.live_total, got.live_total);
        errors++;
      end
      if (got.ignored !== exp.ignored) begin
        $error("ignored: expected %0d actual %0d", exp.ignored, got.ignored);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  depq_scoreboard sb;

  depq_in_if  in_ch();
  depq_out_if out_ch();

  double_ended_priority_queue u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    queue_status_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_command(in_ch.cmd, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        got.empty_res = out_ch.empty_res;
        got.largest = out_ch.largest;
        got.smallest = out_ch.smallest;
        got.live_total = out_ch.live_total;
        got.ignored = out_ch.ignored;
        sb.check_status(got);
      end
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 20);
  end

  task automatic send_command(logic [1:0] cmd, int value);
    if (!no_idle && $urandom_range(99) < 20) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(8) - 4;
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(2)
                                  : 32'h80000000 + $urandom_range(2);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int n, int clear_pct, int ins_pct);
    int r;
    int mid;
    mid = ins_pct + (100 - ins_pct) / 2;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < clear_pct) send_command(depq_pkg::CMD_CLEAR, $urandom);
      else if (r < ins_pct) send_command(depq_pkg::CMD_INSERT, pick_value());
      else if (r < mid) send_command(depq_pkg::CMD_DEL_MIN, $urandom);
      else send_command(depq_pkg::CMD_DEL_MAX, $urandom);
    end
  endtask

  initial begin
    sb = new();
    no_idle = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.cmd = depq_pkg::CMD_CLEAR;
    in_ch.value = 0;
    out_ch.ready = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_command(depq_pkg::CMD_DEL_MIN, 0);
    send_command(depq_pkg::CMD_DEL_MAX, -1);
    send_command(depq_pkg::CMD_INSERT, 32'h80000000);
    send_command(depq_pkg::CMD_INSERT, 32'h7fffffff);
    send_command(depq_pkg::CMD_INSERT, 0);
    send_command(depq_pkg::CMD_INSERT, -1);
    send_command(depq_pkg::CMD_INSERT, -1);
    send_command(depq_pkg::CMD_DEL_MAX, 0);
    send_command(depq_pkg::CMD_DEL_MIN, 0);
    send_command(depq_pkg::CMD_DEL_MIN, 0);
    send_command(depq_pkg::CMD_DEL_MAX, 0);
    send_command(depq_pkg::CMD_DEL_MIN, 0);
    send_command(depq_pkg::CMD_DEL_MIN, 0);
    send_command(depq_pkg::CMD_INSERT, 5);
    send_command(depq_pkg::CMD_CLEAR, 0);
    send_command(depq_pkg::CMD_DEL_MAX, 0);
    send_command(depq_pkg::CMD_INSERT, 7);
    send_command(depq_pkg::CMD_INSERT, 7);
    send_command(depq_pkg::CMD_DEL_MIN, 0);

    send_random(250, 3, 55);
    no_idle = 1;
    send_random(150, 3, 55);
    no_idle = 0;

    // deep heaps, with deletes mixed in so stale tops pile up
    send_command(depq_pkg::CMD_CLEAR, 0);
    send_random(350, 0, 75);
    send_random(30, 3, 55);

    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
